// ===== rtl/wdt_pkg.sv =====
`default_nettype none
package wdt_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned OffW  = 12;
	localparam int unsigned CtrlW = 2;

	localparam logic [DataW-1:0] UNLOCK_KEY = 32'h1ACC_E551;
	localparam logic [DataW-1:0] ALL_ONES   = 32'hFFFF_FFFF;

	// Register byte offsets
	localparam logic [OffW-1:0] OFF_LOAD   = 12'h000;
	localparam logic [OffW-1:0] OFF_VALUE  = 12'h004;
	localparam logic [OffW-1:0] OFF_CTRL   = 12'h008;
	localparam logic [OffW-1:0] OFF_INTCLR = 12'h00C;
	localparam logic [OffW-1:0] OFF_RIS    = 12'h010;
	localparam logic [OffW-1:0] OFF_MIS    = 12'h014;
	localparam logic [OffW-1:0] OFF_LOCK   = 12'hC00;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [DataW-1:0] rdata;
		logic             irq;
		logic             reset_request;
		logic             bad_access;
	} wdt_res_t;

endpackage
`default_nettype wire

// ===== rtl/wdt_core.sv =====
`default_nettype none
module wdt_core
	import wdt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [1:0]       cmd,
	input  wire logic [OffW-1:0]  offset,
	input  wire logic [DataW-1:0] wdata,
	output wdt_res_t              res
);

	logic [DataW-1:0] period_q, count_q;
	logic [CtrlW-1:0] ctrl_q;
	logic             pending_q, lock_q, halted_q;

	logic [DataW-1:0] period_d, count_d;
	logic [CtrlW-1:0] ctrl_d;
	logic             pending_d, lock_d, halted_d;

	always_comb begin
		period_d  = period_q;
		count_d   = count_q;
		ctrl_d    = ctrl_q;
		pending_d = pending_q;
		lock_d    = lock_q;
		halted_d  = halted_q;
		res       = '0;

		unique case (cmd_t'(cmd))
			CMD_TICK: begin
				if (ctrl_q[0] && !halted_q) begin
					if (count_q > DataW'(1)) begin
						count_d = count_q - DataW'(1);
					end else if (ctrl_q[1] && pending_q) begin
						// second timeout: pulse reset and stop until reload
						halted_d          = 1'b1;
						count_d           = '0;
						res.reset_request = 1'b1;
					end else begin
						pending_d = 1'b1;
						count_d   = period_q;
					end
				end
			end
			CMD_READ: begin
				unique case (offset)
					OFF_LOAD:  res.rdata = period_q;
					OFF_VALUE: res.rdata = count_q;
					OFF_CTRL:  res.rdata = DataW'(ctrl_q);
					OFF_RIS:   res.rdata = DataW'(pending_q);
					OFF_MIS:   res.rdata = DataW'(ctrl_q[0] & pending_q);
					OFF_LOCK:  res.rdata = DataW'(lock_q);
					default:   res.bad_access = 1'b1;
				endcase
			end
			CMD_WRITE: begin
				unique case (offset)
					OFF_LOAD: begin
						if (!lock_q) begin
							period_d = wdata;
							if (ctrl_q[0]) begin
								count_d  = wdata;
								halted_d = 1'b0;
							end
						end
					end
					OFF_CTRL: begin
						if (!lock_q) begin
							ctrl_d = wdata[CtrlW-1:0];
							if (!ctrl_q[0] && wdata[0]) begin
								count_d  = period_q;
								halted_d = 1'b0;
							end
						end
					end
					OFF_INTCLR: begin
						if (!lock_q) begin
							pending_d = 1'b0;
							if (ctrl_q[0]) begin
								count_d  = period_q;
								halted_d = 1'b0;
							end
						end
					end
					OFF_LOCK: lock_d = (wdata != UNLOCK_KEY);
					default:  res.bad_access = 1'b1;
				endcase
			end
			default: ;
		endcase

		res.irq = ctrl_d[0] & pending_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= ALL_ONES;
			count_q   <= ALL_ONES;
			ctrl_q    <= '0;
			pending_q <= 1'b0;
			lock_q    <= 1'b0;
			halted_q  <= 1'b0;
		end else if (step) begin
			period_q  <= period_d;
			count_q   <= count_d;
			ctrl_q    <= ctrl_d;
			pending_q <= pending_d;
			lock_q    <= lock_d;
			halted_q  <= halted_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/watchdog_timer_with_lock.sv =====
// Watchdog timer with a lock register.
//
// Input channel (in_valid / in_stall): one beat per item, carrying cmd
// (tick, register read or register write), a 12-bit register offset and
// 32-bit write data. Output channel (out_valid / out_stall): one beat per
// input beat, in order, carrying rdata, irq, reset_request and bad_access.
//
// A beat taken from the input lands in the input register, is executed
// against the watchdog state when it advances, and its result is written
// into the result register, which drives the output channel; a stall on
// the output can hold the beat in the input register meanwhile.
// Throughput: one beat per cycle while the output is not stalled; every
// item is a single combinational pass over the register state.
//
// Stalling: the output register holds its beat while out_stall is high;
// the input register still takes one more beat, after which in_stall is
// raised until the output moves. No beat is lost or repeated.
//
// Reset (arst_n low): load and count go to all ones, control, pending,
// lock and halt clear, and both pipeline registers empty.
`default_nettype none
module watchdog_timer_with_lock
	import wdt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       cmd,
	input  wire logic [OffW-1:0]  offset,
	input  wire logic [DataW-1:0] wdata,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [DataW-1:0]      rdata,
	output logic                  irq,
	output logic                  reset_request,
	output logic                  bad_access
);

	// Input register
	logic             valid_s1;
	logic [1:0]       cmd_s1;
	logic [OffW-1:0]  offset_s1;
	logic [DataW-1:0] wdata_s1;

	// Result register
	logic     out_valid_q;
	wdt_res_t res_q;
	wdt_res_t res;

	logic in_acc, adv;

	// advance the held item whenever the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1    <= cmd;
			offset_s1 <= offset;
			wdata_s1  <= wdata;
		end
	end

	// State is updated only when the item leaves the input register
	wdt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.cmd    (cmd_s1),
		.offset (offset_s1),
		.wdata  (wdata_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign rdata         = res_q.rdata;
	assign irq           = res_q.irq;
	assign reset_request = res_q.reset_request;
	assign bad_access    = res_q.bad_access;

	// A reset request only fires with the interrupt both enabled and pending
	a_rst_implies_irq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reset_request |-> irq)
		else $error("reset_request without irq");

	// A flagged access never returns data
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_access |-> rdata == '0)
		else $error("bad_access with non-zero rdata");

	// Hold off the source only while an item waits in the input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked item");

	// An advancing item always shows up on the output next cycle
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced item lost");

endmodule
`default_nettype wire
